FILE: rtl/audio_stream_receive_filter_top_defines.svh
// Assertion macros used by the audio stream receive filter checker.
`ifndef AUDIO_STREAM_RECEIVE_FILTER_TOP_DEFINES_SVH
`define AUDIO_STREAM_RECEIVE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define ASRF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define ASRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/asrf_pkg.sv
// Types, constants and status codes of the audio stream receive filter.
`timescale 1ns / 1ps
package asrf_pkg;

	// Frame format constants.
	localparam logic [10:0] MAX_FRAME_BYTES = 11'd250;
	localparam logic [7:0]  HDR_BYTES       = 8'd33;
	localparam logic [31:0] AUDIO_MAGIC     = 32'h5754_3031;
	localparam logic [7:0]  AUDIO_TYPE      = 8'd1;
	localparam logic [7:0]  CODEC_OPUS      = 8'd2;
	localparam int          FLAG_END_BIT    = 1;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd1200;

	// Queue depths between the parts.
	localparam int MID_DEPTH_DEFAULT = 2;
	localparam int OUT_DEPTH_DEFAULT = 2;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_MALFORMED = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_STALE     = 3'd2,
		ST_ACCEPTED  = 3'd3,
		ST_TIMED_OUT = 3'd4,
		ST_IDLE_TICK = 3'd5
	} status_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		logic        tick;
		logic        malformed;
		logic        end_flag;
		logic [63:0] id_high;
		logic [63:0] id_low;
		logic [31:0] seq;
		logic [16:0] main_offset;
		logic [17:0] redundant_offset;
		logic [15:0] main_bytes;
		logic [15:0] redundant_bytes;
	} mid_item_t;

	// One result item.
	typedef struct packed {
		status_t     status;
		logic        new_stream;
		logic        play_redundant;
		logic [17:0] redundant_offset;
		logic [15:0] redundant_bytes;
		logic        play_main;
		logic [16:0] main_offset;
		logic [15:0] main_bytes;
		logic        stream_finished;
		logic        receiving;
	} result_t;

endpackage

FILE: rtl/asrf_fifo.sv
// Small register queue with first-word-fall-through read.
`timescale 1ns / 1ps
module asrf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Storage is written only on a transfer in.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: rtl/asrf_front.sv
// Front part: header validation and payload offset computation.
`timescale 1ns / 1ps
module asrf_front (
	input  logic               kind,
	input  logic [7:0]         frame_length,
	input  logic [31:0]        magic,
	input  logic [7:0]         packet_type,
	input  logic [7:0]         packet_flags,
	input  logic [15:0]        sender_length,
	input  logic [63:0]        stream_id_high,
	input  logic [63:0]        stream_id_low,
	input  logic [31:0]        sequence_req,
	input  logic [15:0]        payload_length,
	input  logic [15:0]        redundant_length,
	input  logic [7:0]         codec,
	output asrf_pkg::mid_item_t item
);
	logic [16:0] main_off;
	logic [17:0] red_off;
	logic [17:0] need;
	logic        bad_len;

	// Offsets and the total declared length, summed without wrap.
	assign main_off = 17'(asrf_pkg::HDR_BYTES) + 17'(sender_length);
	assign red_off  = 18'(main_off) + 18'(payload_length);
	assign need     = red_off + 18'(redundant_length);

	// Frame length must lie in the header-to-maximum window and hold all fields.
	assign bad_len = (11'(frame_length) > asrf_pkg::MAX_FRAME_BYTES)
		|| (frame_length < asrf_pkg::HDR_BYTES)
		|| (need > 18'(frame_length));

	always_comb begin
		item.tick             = kind;
		item.malformed        = bad_len || (magic != asrf_pkg::AUDIO_MAGIC)
			|| (packet_type != asrf_pkg::AUDIO_TYPE) || (codec != asrf_pkg::CODEC_OPUS);
		item.end_flag         = packet_flags[asrf_pkg::FLAG_END_BIT];
		item.id_high          = stream_id_high;
		item.id_low           = stream_id_low;
		item.seq              = sequence_req;
		item.main_offset      = main_off;
		item.redundant_offset = red_off;
		item.main_bytes       = payload_length;
		item.redundant_bytes  = redundant_length;
	end
endmodule

FILE: rtl/asrf_back.sv
// Back part: stream tracking, duplicate and stale filtering, idle timeout.
`timescale 1ns / 1ps
module asrf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                mid_empty,
	input  asrf_pkg::mid_item_t mid_item,
	output logic                mid_pop,
	input  logic                out_full,
	output logic                out_push,
	output asrf_pkg::result_t   out_item
);
	logic [15:0] timeout_q;
	logic [63:0] cur_id_hi_q, cur_id_lo_q, fin_id_hi_q, fin_id_lo_q;
	logic [31:0] cur_seq_q, fin_seq_q;
	logic        cur_valid_q, fin_valid_q;
	logic [15:0] idle_q;

	logic [63:0] cur_id_hi_d, cur_id_lo_d, fin_id_hi_d, fin_id_lo_d;
	logic [31:0] cur_seq_d, fin_seq_d;
	logic        cur_valid_d, fin_valid_d;
	logic [15:0] idle_d;
	logic        is_new;
	logic        fin_match;
	logic [31:0] next_seq;
	logic        do_close;

	// One item moves whenever one is waiting and the result queue has room.
	assign mid_pop  = !mid_empty && !out_full;
	assign out_push = mid_pop;

	assign is_new    = !cur_valid_q || (cur_id_hi_q != mid_item.id_high)
		|| (cur_id_lo_q != mid_item.id_low);
	assign fin_match = fin_valid_q && (fin_id_hi_q == mid_item.id_high)
		&& (fin_id_lo_q == mid_item.id_low) && (mid_item.seq <= fin_seq_q);
	assign next_seq  = cur_seq_q + 32'd1;

	// Classify the item against stream state and compute the next state.
	always_comb begin
		cur_id_hi_d = cur_id_hi_q;
		cur_id_lo_d = cur_id_lo_q;
		cur_seq_d   = cur_seq_q;
		cur_valid_d = cur_valid_q;
		fin_id_hi_d = fin_id_hi_q;
		fin_id_lo_d = fin_id_lo_q;
		fin_seq_d   = fin_seq_q;
		fin_valid_d = fin_valid_q;
		idle_d      = idle_q;
		do_close    = 1'b0;
		out_item    = '0;

		if (mid_item.tick) begin
			out_item.status = asrf_pkg::ST_IDLE_TICK;
			if (cur_valid_q) begin
				if (idle_q >= timeout_q) begin
					do_close                 = 1'b1;
					out_item.status          = asrf_pkg::ST_TIMED_OUT;
					out_item.stream_finished = 1'b1;
				end else begin
					idle_d = idle_q + 16'd1;
				end
			end
		end else if (mid_item.malformed) begin
			out_item.status = asrf_pkg::ST_MALFORMED;
		end else if (fin_match) begin
			out_item.status = asrf_pkg::ST_DUPLICATE;
		end else if (!is_new && (mid_item.seq <= cur_seq_q)) begin
			out_item.status = asrf_pkg::ST_STALE;
		end else begin
			out_item.status           = asrf_pkg::ST_ACCEPTED;
			out_item.new_stream       = is_new;
			out_item.play_redundant   = !is_new && (mid_item.seq > next_seq)
				&& (mid_item.redundant_bytes != 16'd0);
			out_item.redundant_offset = mid_item.redundant_offset;
			out_item.redundant_bytes  = mid_item.redundant_bytes;
			out_item.play_main        = (mid_item.main_bytes != 16'd0);
			out_item.main_offset      = mid_item.main_offset;
			out_item.main_bytes       = mid_item.main_bytes;
			out_item.stream_finished  = mid_item.end_flag;
			cur_id_hi_d = mid_item.id_high;
			cur_id_lo_d = mid_item.id_low;
			cur_seq_d   = mid_item.seq;
			cur_valid_d = 1'b1;
			idle_d      = 16'd0;
			do_close    = mid_item.end_flag;
		end

		// Closing moves the current stream, as just updated, to completed.
		if (do_close) begin
			fin_id_hi_d = cur_id_hi_d;
			fin_id_lo_d = cur_id_lo_d;
			fin_seq_d   = cur_seq_d;
			fin_valid_d = 1'b1;
			cur_valid_d = 1'b0;
			idle_d      = 16'd0;
		end

		out_item.receiving = cur_valid_d;
	end

	// Timeout register; the user must write it only while the block is idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= asrf_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Stream state advances on each transfer through the back part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_id_hi_q <= '0;
			cur_id_lo_q <= '0;
			cur_seq_q   <= '0;
			cur_valid_q <= 1'b0;
			fin_id_hi_q <= '0;
			fin_id_lo_q <= '0;
			fin_seq_q   <= '0;
			fin_valid_q <= 1'b0;
			idle_q      <= '0;
		end else if (mid_pop) begin
			cur_id_hi_q <= cur_id_hi_d;
			cur_id_lo_q <= cur_id_lo_d;
			cur_seq_q   <= cur_seq_d;
			cur_valid_q <= cur_valid_d;
			fin_id_hi_q <= fin_id_hi_d;
			fin_id_lo_q <= fin_id_lo_d;
			fin_seq_q   <= fin_seq_d;
			fin_valid_q <= fin_valid_d;
			idle_q      <= idle_d;
		end
	end
endmodule

FILE: rtl/audio_stream_receive_filter_top.sv
// Top level of the audio stream receive filter.
// Usage:
// Items enter through push/full: an item transfers on a rising edge with push
// high and full low. Each item is a parsed packet header (kind 0) or a one
// millisecond tick (kind 1) and yields exactly one result.
// Results leave through empty/pop: the oldest result is on the result ports
// while empty is low and transfers on a rising edge with pop high.
// The timeout is written through cfg_we/cfg_wdata while no item is in flight.
// After it transfers in, an item waits in the classify queue, then its result is
// registered in the result queue and can transfer out on a rising edge with pop high.
// Throughput: one item per cycle while the result queue has room; the back part
// updates the stream state for each item as it passes, so the back part sets the rate.
// A stalled receiver fills the result queue, the back part then holds, the
// classify queue fills behind it and full rises; nothing is lost.
// Reset clears both queues and the stream state; the timeout returns to 1200
// ticks. No clearing pass follows reset.
`timescale 1ns / 1ps
module audio_stream_receive_filter_top #(
	parameter int MID_DEPTH = asrf_pkg::MID_DEPTH_DEFAULT,
	parameter int OUT_DEPTH = asrf_pkg::OUT_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  frame_length,
	input  logic [31:0] magic,
	input  logic [7:0]  packet_type,
	input  logic [7:0]  packet_flags,
	input  logic [15:0] sender_length,
	input  logic [63:0] stream_id_high,
	input  logic [63:0] stream_id_low,
	input  logic [31:0] sequence_req,
	input  logic [15:0] payload_length,
	input  logic [15:0] redundant_length,
	input  logic [7:0]  codec,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic        new_stream,
	output logic        play_redundant,
	output logic [17:0] redundant_offset,
	output logic [15:0] redundant_bytes,
	output logic        play_main,
	output logic [16:0] main_offset,
	output logic [15:0] main_bytes,
	output logic        stream_finished,
	output logic        receiving
);
	localparam int MidW = $bits(asrf_pkg::mid_item_t);
	localparam int OutW = $bits(asrf_pkg::result_t);

	asrf_pkg::mid_item_t front_item;
	asrf_pkg::mid_item_t mid_item;
	asrf_pkg::result_t   back_item;
	asrf_pkg::result_t   res;
	logic                mid_empty;
	logic                mid_pop;
	logic                out_full;
	logic                out_push;

	// Front part: classify each header as it transfers in.
	asrf_front u_front (
		.kind             (kind),
		.frame_length     (frame_length),
		.magic            (magic),
		.packet_type      (packet_type),
		.packet_flags     (packet_flags),
		.sender_length    (sender_length),
		.stream_id_high   (stream_id_high),
		.stream_id_low    (stream_id_low),
		.sequence_req     (sequence_req),
		.payload_length   (payload_length),
		.redundant_length (redundant_length),
		.codec            (codec),
		.item             (front_item)
	);

	// Queue between the front and back parts.
	asrf_fifo #(.WIDTH(MidW), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.empty  (mid_empty)
	);

	// Back part: stream state and result generation.
	asrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mid_empty (mid_empty),
		.mid_item  (mid_item),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (back_item)
	);

	// Result queue toward the receiver.
	asrf_fifo #(.WIDTH(OutW), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (back_item),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res),
		.empty  (empty)
	);

	assign status           = res.status;
	assign new_stream       = res.new_stream;
	assign play_redundant   = res.play_redundant;
	assign redundant_offset = res.redundant_offset;
	assign redundant_bytes  = res.redundant_bytes;
	assign play_main        = res.play_main;
	assign main_offset      = res.main_offset;
	assign main_bytes       = res.main_bytes;
	assign stream_finished  = res.stream_finished;
	assign receiving        = res.receiving;
endmodule

FILE: rtl/asrf_checker.sv
// Port-level checker for the audio stream receive filter, bound to the top level.
`timescale 1ns / 1ps
`include "audio_stream_receive_filter_top_defines.svh"
module asrf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  status,
	input logic        new_stream,
	input logic        play_redundant,
	input logic        play_main,
	input logic [15:0] main_bytes,
	input logic        stream_finished,
	input logic        receiving
);
	// A result that was not accepted carries no playback request.
	`ASRF_ASSERT_NOW(a_reject_quiet, !empty && (status != asrf_pkg::ST_ACCEPTED), !new_stream && !play_redundant && !play_main && (main_bytes == 16'd0), "rejected result carries playback fields")

	// A timeout always closes the stream, and a closed stream is not receiving.
	`ASRF_ASSERT_NOW(a_timeout_closes, !empty && (status == asrf_pkg::ST_TIMED_OUT), stream_finished && !receiving, "timeout result without stream close")

	// A newly started stream is either receiving or closed by its end flag.
	`ASRF_ASSERT_NOW(a_new_stream_live, !empty && new_stream, receiving || stream_finished, "new stream neither active nor closed")

	// A result waiting for the receiver stays put.
	`ASRF_ASSERT_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(status) && $stable(receiving), "stalled result changed")
endmodule

bind audio_stream_receive_filter_top asrf_checker u_asrf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.status          (status),
	.new_stream      (new_stream),
	.play_redundant  (play_redundant),
	.play_main       (play_main),
	.main_bytes      (main_bytes),
	.stream_finished (stream_finished),
	.receiving       (receiving)
);

FILE: dv/audio_stream_receive_filter_top_tb.sv
// Self-checking testbench for the audio stream receive filter top level.
`timescale 1ns / 1ps
module audio_stream_receive_filter_top_tb;

	// One input item with the fields at the port widths.
	typedef struct packed {
		logic        kind;
		logic [7:0]  flen;
		logic [31:0] magic;
		logic [7:0]  ptype;
		logic [7:0]  flags;
		logic [15:0] slen;
		logic [63:0] id_hi;
		logic [63:0] id_lo;
		logic [31:0] seq;
		logic [15:0] plen;
		logic [15:0] rlen;
		logic [7:0]  codec;
	} pkt_item_t;

	localparam int MAX_REPORTS = 40;

	// Block ports.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        push = 1'b0;
	logic        full;
	logic        kind = 1'b0;
	logic [7:0]  frame_length = '0;
	logic [31:0] magic = '0;
	logic [7:0]  packet_type = '0;
	logic [7:0]  packet_flags = '0;
	logic [15:0] sender_length = '0;
	logic [63:0] stream_id_high = '0;
	logic [63:0] stream_id_low = '0;
	logic [31:0] sequence_req = '0;
	logic [15:0] payload_length = '0;
	logic [15:0] redundant_length = '0;
	logic [7:0]  codec = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  status;
	logic        new_stream;
	logic        play_redundant;
	logic [17:0] redundant_offset;
	logic [15:0] redundant_bytes;
	logic        play_main;
	logic [16:0] main_offset;
	logic [15:0] main_bytes;
	logic        stream_finished;
	logic        receiving;

	// Predicted stream state and timeout setting.
	logic [63:0] act_id_hi = '0;
	logic [63:0] act_id_lo = '0;
	logic        act_valid = 1'b0;
	logic [31:0] act_seq = '0;
	logic [63:0] done_id_hi = '0;
	logic [63:0] done_id_lo = '0;
	logic        done_valid = 1'b0;
	logic [31:0] done_seq = '0;
	logic [15:0] idle_ticks = '0;
	logic [15:0] idle_limit = asrf_pkg::TIMEOUT_RESET;

	// Verdicts awaiting their result transfer, and run bookkeeping.
	asrf_pkg::result_t pending_verdicts[$];
	int mismatches = 0;
	int items_sent = 0;
	int pop_hold = 0;
	bit tx_throttle = 1'b1;
	bit rx_throttle = 1'b1;
	logic [63:0] pool_hi [6];
	logic [63:0] pool_lo [6];

	audio_stream_receive_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.kind(kind),
		.frame_length(frame_length),
		.magic(magic),
		.packet_type(packet_type),
		.packet_flags(packet_flags),
		.sender_length(sender_length),
		.stream_id_high(stream_id_high),
		.stream_id_low(stream_id_low),
		.sequence_req(sequence_req),
		.payload_length(payload_length),
		.redundant_length(redundant_length),
		.codec(codec),
		.empty(empty),
		.pop(pop),
		.status(status),
		.new_stream(new_stream),
		.play_redundant(play_redundant),
		.redundant_offset(redundant_offset),
		.redundant_bytes(redundant_bytes),
		.play_main(play_main),
		.main_offset(main_offset),
		.main_bytes(main_bytes),
		.stream_finished(stream_finished),
		.receiving(receiving)
	);

	always #6 clk = ~clk;

	// Moves the current stream, if any, to the completed slot.
	function automatic void close_current();
		if (act_valid) begin
			done_id_hi = act_id_hi;
			done_id_lo = act_id_lo;
			done_seq = act_seq;
			done_valid = 1'b1;
		end
		act_valid = 1'b0;
		idle_ticks = '0;
	endfunction

	// Works out the filter verdict for one item and advances the stream state.
	function automatic asrf_pkg::result_t filter_verdict(pkt_item_t it);
		asrf_pkg::result_t r;
		int unsigned need;
		logic is_new;
		logic [31:0] next_seq;
		r = '0;
		r.status = asrf_pkg::ST_IDLE_TICK;
		if (it.kind) begin
			if (act_valid) begin
				if (idle_ticks >= idle_limit) begin
					close_current();
					r.status = asrf_pkg::ST_TIMED_OUT;
					r.stream_finished = 1'b1;
				end else begin
					idle_ticks = idle_ticks + 16'd1;
				end
			end
		end else begin
			need = 32'(asrf_pkg::HDR_BYTES) + 32'(it.slen) + 32'(it.plen) + 32'(it.rlen);
			if (it.flen > asrf_pkg::MAX_FRAME_BYTES || it.flen < asrf_pkg::HDR_BYTES
					|| it.magic != asrf_pkg::AUDIO_MAGIC
					|| it.ptype != asrf_pkg::AUDIO_TYPE || need > 32'(it.flen)
					|| it.codec != asrf_pkg::CODEC_OPUS) begin
				r.status = asrf_pkg::ST_MALFORMED;
			end else if (done_valid && done_id_hi == it.id_hi && done_id_lo == it.id_lo
					&& it.seq <= done_seq) begin
				r.status = asrf_pkg::ST_DUPLICATE;
			end else begin
				is_new = !act_valid || act_id_hi != it.id_hi || act_id_lo != it.id_lo;
				if (!is_new && it.seq <= act_seq) begin
					r.status = asrf_pkg::ST_STALE;
				end else begin
					// The gap test uses the last sequence plus one, wrapping at 32 bits.
					next_seq = act_seq + 32'd1;
					if (is_new) begin
						act_id_hi = it.id_hi;
						act_id_lo = it.id_lo;
						act_valid = 1'b1;
					end
					idle_ticks = '0;
					r.play_redundant = !is_new && it.seq > next_seq && it.rlen != 0;
					act_seq = it.seq;
					r.status = asrf_pkg::ST_ACCEPTED;
					r.new_stream = is_new;
					r.main_offset = 17'(asrf_pkg::HDR_BYTES) + 17'(it.slen);
					r.redundant_offset = 18'(asrf_pkg::HDR_BYTES) + 18'(it.slen)
						+ 18'(it.plen);
					r.main_bytes = it.plen;
					r.redundant_bytes = it.rlen;
					r.play_main = it.plen != 0;
					if (it.flags[asrf_pkg::FLAG_END_BIT]) begin
						close_current();
						r.stream_finished = 1'b1;
					end
				end
			end
		end
		r.receiving = act_valid;
		return r;
	endfunction

	// Most gaps are short, a few are long.
	function automatic int rand_gap();
		if ($urandom_range(0, 9) < 8)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 30));
	endfunction

	// A well-formed header with explicit lengths.
	function automatic pkt_item_t hdr(logic [63:0] hi, logic [63:0] lo, logic [31:0] seq,
			logic [7:0] flen, logic [15:0] slen, logic [15:0] plen, logic [15:0] rlen,
			logic [7:0] flags);
		pkt_item_t it;
		it.kind = 1'b0;
		it.flen = flen;
		it.magic = asrf_pkg::AUDIO_MAGIC;
		it.ptype = asrf_pkg::AUDIO_TYPE;
		it.flags = flags;
		it.slen = slen;
		it.id_hi = hi;
		it.id_lo = lo;
		it.seq = seq;
		it.plen = plen;
		it.rlen = rlen;
		it.codec = asrf_pkg::CODEC_OPUS;
		return it;
	endfunction

	// A header of random item with every field drawn at random.
	function automatic pkt_item_t make_noise();
		pkt_item_t it;
		it.kind = 1'b0;
		it.flen = 8'($urandom);
		it.magic = $urandom;
		it.ptype = 8'($urandom);
		it.flags = 8'($urandom);
		it.slen = 16'($urandom);
		it.id_hi = {$urandom, $urandom};
		it.id_lo = {$urandom, $urandom};
		it.seq = $urandom;
		it.plen = 16'($urandom);
		it.rlen = 16'($urandom);
		it.codec = 8'($urandom);
		return it;
	endfunction

	// A tick; its other fields carry random values that the block ignores.
	function automatic pkt_item_t make_tick();
		pkt_item_t it;
		it = make_noise();
		it.kind = 1'b1;
		return it;
	endfunction

	// A well-formed header with random lengths that fit the frame.
	function automatic pkt_item_t make_header(logic [63:0] hi, logic [63:0] lo,
			logic [31:0] seq, bit last);
		int flen, budget, slen, plen, rlen;
		flen = $urandom_range(33, 250);
		budget = flen - 33;
		slen = $urandom_range(0, budget);
		budget -= slen;
		plen = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(0, budget));
		budget -= plen;
		rlen = $urandom_range(0, budget);
		return hdr(hi, lo, seq, 8'(flen), 16'(slen), 16'(plen), 16'(rlen),
			(8'($urandom) & 8'hFD) | {6'd0, last, 1'b0});
	endfunction

	// Breaks one rule of the header format.
	function automatic pkt_item_t corrupt(pkt_item_t it);
		case ($urandom_range(0, 6))
			0: it.flen = 8'($urandom_range(0, 32));
			1: it.flen = 8'($urandom_range(251, 255));
			2: it.magic = it.magic ^ (32'd1 << $urandom_range(0, 31));
			3: begin
				it.ptype = 8'($urandom);
				if (it.ptype == asrf_pkg::AUDIO_TYPE)
					it.ptype = 8'd0;
			end
			4: begin
				it.codec = 8'($urandom);
				if (it.codec == asrf_pkg::CODEC_OPUS)
					it.codec = 8'd0;
			end
			5: begin
				it.slen = 16'($urandom);
				it.plen = 16'($urandom);
				it.rlen = 16'($urandom);
			end
			default: it.rlen = 16'(32'(it.flen) - 33 - 32'(it.slen) - 32'(it.plen) + 1);
		endcase
		return it;
	endfunction

	// Offers one item and waits for its transfer; push stays high afterwards.
	task automatic send_item(pkt_item_t it);
		int gap;
		if (tx_throttle && $urandom_range(0, 2) == 0) begin
			gap = rand_gap();
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		kind <= it.kind;
		frame_length <= it.flen;
		magic <= it.magic;
		packet_type <= it.ptype;
		packet_flags <= it.flags;
		sender_length <= it.slen;
		stream_id_high <= it.id_hi;
		stream_id_low <= it.id_lo;
		sequence_req <= it.seq;
		payload_length <= it.plen;
		redundant_length <= it.rlen;
		codec <= it.codec;
		do @(posedge clk); while (full);
		pending_verdicts.push_back(filter_verdict(it));
		items_sent++;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(make_tick());
	endtask

	// Stops offering and waits until every result has come out.
	task automatic drain_pending();
		@(negedge clk);
		push <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes the timeout register while the block is idle.
	task automatic set_timeout(logic [15:0] value);
		drain_pending();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		idle_limit = value;
	endtask

	// Each header rule broken on its own, and a tick with no stream.
	task automatic test_malformed();
		pkt_item_t it;
		logic [63:0] hi, lo;
		hi = 64'h0123_4567_89AB_CDEF;
		lo = 64'hFEDC_BA98_7654_3210;
		send_item(hdr(hi, lo, 32'd5, 8'd32, 16'd0, 16'd0, 16'd0, 8'h00));
		send_item(hdr(hi, lo, 32'd5, 8'd251, 16'd0, 16'd0, 16'd0, 8'h00));
		send_item(hdr(hi, lo, 32'd5, 8'd255, 16'd0, 16'd0, 16'd0, 8'h00));
		it = hdr(hi, lo, 32'd5, 8'd100, 16'd4, 16'd20, 16'd6, 8'h00);
		it.magic = asrf_pkg::AUDIO_MAGIC ^ 32'h0000_0001;
		send_item(it);
		it.magic = asrf_pkg::AUDIO_MAGIC;
		it.ptype = 8'd255;
		send_item(it);
		it.ptype = asrf_pkg::AUDIO_TYPE;
		it.codec = 8'd3;
		send_item(it);
		// The length sum must not wrap before it is compared with the frame.
		send_item(hdr(hi, lo, 32'd5, 8'd250, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00));
		send_item(hdr(hi, lo, 32'd5, 8'd100, 16'd30, 16'd30, 16'd8, 8'h00));
		send_item(make_tick());
	endtask

	// Ordering within streams, gaps, stale packets, stream switches and wrap.
	task automatic test_stream_order();
		logic [63:0] hi, lo;
		hi = 64'h0123_4567_89AB_CDEF;
		lo = 64'hFEDC_BA98_7654_3210;
		send_item(hdr(hi, lo, 32'd10, 8'd250, 16'd200, 16'd10, 16'd7, 8'h01));
		send_item(hdr(hi, lo, 32'd11, 8'd33, 16'd0, 16'd0, 16'd0, 8'h00));
		send_item(hdr(hi, lo, 32'd11, 8'd60, 16'd2, 16'd10, 16'd3, 8'h00));
		send_item(hdr(hi, lo, 32'd5, 8'd60, 16'd2, 16'd10, 16'd3, 8'h00));
		send_item(hdr(hi, lo, 32'd14, 8'd80, 16'd5, 16'd20, 16'd4, 8'h00));
		send_item(hdr(hi, lo, 32'd16, 8'd80, 16'd5, 16'd20, 16'd0, 8'h00));
		send_item(hdr(hi, lo, 32'd17, 8'd80, 16'd5, 16'd20, 16'd5, 8'h00));
		// Ids that differ in only one half are different streams.
		send_item(hdr(hi, lo ^ 64'd1, 32'd0, 8'd40, 16'd1, 16'd2, 16'd3, 8'h00));
		send_item(hdr(hi ^ {1'b1, 63'd0}, lo ^ 64'd1, 32'd3, 8'd40, 16'd1, 16'd2, 16'd3,
			8'h00));
		send_item(hdr(hi ^ {1'b1, 63'd0}, lo ^ 64'd1, 32'hFFFF_FFFF, 8'd40, 16'd1, 16'd2,
			16'd3, 8'h00));
		send_item(hdr(hi ^ {1'b1, 63'd0}, lo ^ 64'd1, 32'd0, 8'd40, 16'd1, 16'd2, 16'd3,
			8'h00));
	endtask

	// End flag, late packets of the completed stream and reopening it.
	task automatic test_end_and_duplicate();
		logic [63:0] ones;
		ones = '1;
		send_item(hdr(ones, ones, 32'hFFFF_FFFE, 8'd50, 16'd3, 16'd8, 16'd2, 8'h02));
		send_item(hdr(ones, ones, 32'd7, 8'd50, 16'd3, 16'd8, 16'd2, 8'h00));
		send_item(hdr(ones, ones, 32'hFFFF_FFFE, 8'd50, 16'd3, 16'd8, 16'd2, 8'h00));
		send_item(hdr(ones, ones, 32'hFFFF_FFFF, 8'd50, 16'd3, 16'd8, 16'd2, 8'h00));
		send_item(hdr(ones, ones, 32'hFFFF_FFFF, 8'd50, 16'd3, 16'd8, 16'd2, 8'h00));
		send_item(hdr('0, '0, 32'd1, 8'd50, 16'd3, 16'd8, 16'd2, 8'hFF));
		send_item(make_tick());
	endtask

	// Idle timeout at the small settings, zero closing on the first tick.
	task automatic test_short_timeouts();
		logic [63:0] hi, lo;
		hi = {$urandom, $urandom};
		lo = {$urandom, $urandom};
		set_timeout(16'd1);
		send_item(hdr(hi, lo, 32'd0, 8'd40, 16'd1, 16'd2, 16'd3, 8'h00));
		send_ticks(3);
		send_item(hdr(hi, lo, 32'd0, 8'd40, 16'd1, 16'd2, 16'd3, 8'h00));
		set_timeout(16'd0);
		send_item(hdr(hi ^ 64'd2, lo, 32'd2, 8'd40, 16'd1, 16'd2, 16'd3, 8'h00));
		send_ticks(2);
	endtask

	// The largest timeout keeps a stream open over a run of back-to-back ticks.
	task automatic test_max_timeout();
		set_timeout(16'hFFFF);
		tx_throttle = 1'b0;
		rx_throttle = 1'b0;
		send_item(make_header({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 1'b0));
		send_ticks(40);
		tx_throttle = 1'b1;
		rx_throttle = 1'b1;
	endtask

	// The receiver holds off while the sender keeps offering, so full rises.
	task automatic test_backpressure();
		logic [63:0] hi, lo;
		hi = {$urandom, $urandom};
		lo = {$urandom, $urandom};
		set_timeout(16'd3);
		tx_throttle = 1'b0;
		@(posedge clk);
		pop_hold = 80;
		for (int i = 0; i < 24; i++) begin
			if (i % 3 == 2)
				send_item(make_tick());
			else
				send_item(make_header(hi, lo, 32'(i), 1'b0));
		end
		tx_throttle = 1'b1;
	endtask

	// One stream of mostly in-order packets with gaps, stale and broken ones.
	task automatic play_stream();
		logic [63:0] hi, lo;
		logic [31:0] seq;
		int k, roll;
		if ($urandom_range(0, 9) == 0) begin
			send_item(make_noise());
			return;
		end
		if ($urandom_range(0, 9) < 7) begin
			k = $urandom_range(0, 5);
			hi = pool_hi[k];
			lo = pool_lo[k];
		end else begin
			hi = {$urandom, $urandom};
			lo = {$urandom, $urandom};
		end
		case ($urandom_range(0, 4))
			0, 1: seq = $urandom_range(0, 20);
			2, 3: seq = $urandom;
			default: seq = 32'hFFFF_FFFF - $urandom_range(0, 12);
		endcase
		send_item(make_header(hi, lo, seq, 1'b0));
		repeat ($urandom_range(1, 10)) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				send_item(corrupt(make_header(hi, lo, seq + 32'd1, 1'b0)));
			end else if (roll < 18) begin
				send_item(make_header(hi, lo, seq - $urandom_range(0, 3), 1'b0));
			end else if (roll < 30) begin
				seq = seq + $urandom_range(2, 5);
				send_item(make_header(hi, lo, seq, 1'b0));
			end else begin
				seq = seq + 32'd1;
				send_item(make_header(hi, lo, seq, 1'b0));
			end
			if ($urandom_range(0, 3) == 0)
				send_ticks($urandom_range(1, 4));
		end
		// Close by end flag, by idling, or leave the stream open.
		roll = $urandom_range(0, 9);
		if (roll < 5) begin
			seq = seq + 32'd1;
			send_item(make_header(hi, lo, seq, 1'b1));
		end else if (roll < 8) begin
			send_ticks($urandom_range(1, 12));
		end
		if ($urandom_range(0, 2) == 0)
			send_item(make_header(hi, lo, seq - $urandom_range(0, 5), 1'b0));
	endtask

	// Random streams over several timeout settings.
	task automatic test_random();
		logic [15:0] limits [6] = '{16'd3, 16'd1, 16'd0, 16'd8, 16'hFFFF, 16'd2};
		int start;
		for (int i = 0; i < 6; i++) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
		end
		// Some pool ids share one half with another.
		pool_hi[1] = pool_hi[0];
		pool_lo[2] = pool_lo[0];
		for (int b = 0; b < 6; b++) begin
			set_timeout(limits[b]);
			tx_throttle = (b != 3);
			rx_throttle = (b != 3);
			start = items_sent;
			while (items_sent - start < 175)
				play_stream();
		end
		tx_throttle = 1'b1;
		rx_throttle = 1'b1;
	endtask

	// Receiver: random stalls, plus a long hold-off when a test asks for one.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (rx_throttle && $urandom_range(0, 3) == 0)
					stall = rand_gap();
			end
		end
	end

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Each result transfer is checked against the oldest verdict.
	always @(posedge clk) begin
		asrf_pkg::result_t want;
		if (arst_n && !empty && pop) begin
			if (pending_verdicts.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: result with none expected, expected none, actual status %0d",
						$time, status);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				compare_field("status", want.status, status);
				compare_field("new_stream", want.new_stream, new_stream);
				compare_field("play_redundant", want.play_redundant, play_redundant);
				compare_field("redundant_offset", want.redundant_offset, redundant_offset);
				compare_field("redundant_bytes", want.redundant_bytes, redundant_bytes);
				compare_field("play_main", want.play_main, play_main);
				compare_field("main_offset", want.main_offset, main_offset);
				compare_field("main_bytes", want.main_bytes, main_bytes);
				compare_field("stream_finished", want.stream_finished, stream_finished);
				compare_field("receiving", want.receiving, receiving);
			end
		end
	end

	// Test sequence.
	initial begin
		int waited;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_malformed();
		test_stream_order();
		test_end_and_duplicate();
		test_short_timeouts();
		test_max_timeout();
		test_backpressure();
		test_random();
		@(negedge clk);
		push <= 1'b0;
		waited = 0;
		while (pending_verdicts.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0", $time,
				pending_verdicts.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Run limit.
	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
